// ----- rtl/stpe_pkg.sv -----
`timescale 1ns / 1ps

package stpe_pkg;

    localparam int PHASE_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int TURN_BITS  = 32;
    localparam int OUT_W      = 19;
    localparam int ISQ_STEPS  = 31;

    // stage counts of the three units
    localparam int COS_LAT  = 8;
    localparam int FR_LAT   = 2 + ISQ_STEPS;
    localparam int SC_LAT   = 3;
    localparam int PIPE_LAT = COS_LAT + FR_LAT + SC_LAT;

    localparam logic [30:0] ONE_Q      = 31'h4000_0000;
    localparam logic [30:0] PI_HALF    = 31'd1686629713;
    localparam logic [31:0] THIRD_TURN = 32'h5555_5555;
    localparam logic [31:0] TWO_Q      = 32'h8000_0000;

    // Taylor coefficients in Q30, truncated
    localparam logic [30:0] C2    = 31'((64'd1 << 30) / 64'd2);
    localparam logic [30:0] C6    = 31'((64'd1 << 30) / 64'd6);
    localparam logic [30:0] C24   = 31'((64'd1 << 30) / 64'd24);
    localparam logic [30:0] C120  = 31'((64'd1 << 30) / 64'd120);
    localparam logic [30:0] C720  = 31'((64'd1 << 30) / 64'd720);
    localparam logic [30:0] C5040 = 31'((64'd1 << 30) / 64'd5040);

    // exact floor division of a 30-bit value by 8! and 9! via reciprocal
    localparam int          R8_SH = 46;
    localparam int          R9_SH = 49;
    localparam logic [30:0] R8_M  = 31'(((64'd1 << R8_SH) + 64'd40319) / 64'd40320);
    localparam logic [30:0] R9_M  = 31'(((64'd1 << R9_SH) + 64'd362879) / 64'd362880);

    localparam int          RND_SH      = 38 - FRAC_BITS;
    localparam logic [49:0] RND_HALF    = 50'd1 << (RND_SH - 1);
    localparam logic [49:0] OUT_MAX     = 50'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [49:0] OUT_MIN_MAG = 50'(64'd1 << (OUT_W - 1));

    // sign and magnitude of a Q30 value
    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } sm_t;

    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = a * b;
        return p[60:30];
    endfunction

endpackage

// ----- rtl/stpe_cos.sv -----
`timescale 1ns / 1ps

module stpe_cos import stpe_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [TURN_BITS-1:0] phase,
    output sm_t                  cos_o
);

    logic [1:0]  quad_reg [1:7];
    logic        swap_reg [1:7];
    logic [30:0] t_reg    [1:6];
    logic [30:0] t2_reg   [2:5];
    logic [30:0] c_reg    [3:7];
    logic [30:0] s_reg    [3:7];
    sm_t         cos_reg;

    logic        swap;
    logic [29:0] rf;
    logic [61:0] p8;
    logic [61:0] p9;
    logic [30:0] cr;
    logic [30:0] sr;
    sm_t         cos_next;

    always_comb begin
        swap = phase[29:0] > 30'h2000_0000;
        rf   = swap ? 30'(ONE_Q - {1'b0, phase[29:0]}) : phase[29:0];
        p8   = t2_reg[2] * R8_M;
        p9   = t2_reg[2] * R9_M;
        cr   = swap_reg[7] ? s_reg[7] : c_reg[7];
        sr   = swap_reg[7] ? c_reg[7] : s_reg[7];
        case (quad_reg[7])
            2'd0: cos_next = '{neg: 1'b0, mag: cr};
            2'd1: cos_next = '{neg: 1'b1, mag: sr};
            2'd2: cos_next = '{neg: 1'b1, mag: cr};
            default: cos_next = '{neg: 1'b0, mag: sr};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[1] <= phase[31:30];
            swap_reg[1] <= swap;
            t_reg[1]    <= mul_q30({1'b0, rf}, PI_HALF);
            for (int k = 2; k <= 7; k++) begin
                quad_reg[k] <= quad_reg[k-1];
                swap_reg[k] <= swap_reg[k-1];
            end
            for (int k = 2; k <= 6; k++) begin
                t_reg[k] <= t_reg[k-1];
            end
            t2_reg[2] <= mul_q30(t_reg[1], t_reg[1]);
            for (int k = 3; k <= 5; k++) begin
                t2_reg[k] <= t2_reg[k-1];
            end
            // Horner chain, one product per stage
            c_reg[3] <= C720 - {15'd0, p8[61:R8_SH]};
            s_reg[3] <= C5040 - {18'd0, p9[61:R9_SH]};
            c_reg[4] <= C24 - mul_q30(t2_reg[3], c_reg[3]);
            s_reg[4] <= C120 - mul_q30(t2_reg[3], s_reg[3]);
            c_reg[5] <= C2 - mul_q30(t2_reg[4], c_reg[4]);
            s_reg[5] <= C6 - mul_q30(t2_reg[4], s_reg[4]);
            c_reg[6] <= ONE_Q - mul_q30(t2_reg[5], c_reg[5]);
            s_reg[6] <= ONE_Q - mul_q30(t2_reg[5], s_reg[5]);
            c_reg[7] <= c_reg[6];
            s_reg[7] <= mul_q30(t_reg[6], s_reg[6]);
            cos_reg  <= cos_next;
        end
    end

    assign cos_o = cos_reg;

endmodule

// ----- rtl/stpe_froot.sv -----
`timescale 1ns / 1ps

module stpe_froot import stpe_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  sm_t  cos_a,
    input  sm_t  cos_b,
    output sm_t  root_o
);

    logic [30:0] sqa_reg;
    logic [30:0] sqb_reg;
    logic        neg_reg [0:ISQ_STEPS];
    logic [61:0] rem_reg [0:ISQ_STEPS];
    logic [61:0] res_reg [0:ISQ_STEPS];

    logic [32:0] f;
    logic [32:0] fabs;

    always_comb begin
        f    = {2'b00, ONE_Q} - {2'b00, sqa_reg} - {2'b00, sqb_reg};
        fabs = f[32] ? (33'd0 - f) : f;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqa_reg    <= mul_q30(cos_a.mag, cos_a.mag);
            sqb_reg    <= mul_q30(cos_b.mag, cos_b.mag);
            neg_reg[0] <= f[32];
            rem_reg[0] <= {fabs[31:0], 30'd0};
            res_reg[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar j = 1; j <= ISQ_STEPS; j++) begin : g_step
        localparam logic [61:0] BIT = 62'd1 << (2 * (ISQ_STEPS - j));
        logic [61:0] trial;
        logic        ge;

        always_comb begin
            trial = res_reg[j-1] + BIT;
            ge    = rem_reg[j-1] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[j] <= neg_reg[j-1];
                rem_reg[j] <= ge ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                res_reg[j] <= ge ? ((res_reg[j-1] >> 1) + BIT) : (res_reg[j-1] >> 1);
            end
        end
    end

    assign root_o = '{neg: neg_reg[ISQ_STEPS], mag: res_reg[ISQ_STEPS][30:0]};

endmodule

// ----- rtl/stpe_scale.sv -----
`timescale 1ns / 1ps

module stpe_scale import stpe_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  sm_t              base,
    input  sm_t              fac,
    input  logic [15:0]      radius,
    output logic [OUT_W-1:0] coord
);

    logic [32:0]      m_reg;
    logic             neg1_reg;
    logic [49:0]      m2_reg;
    logic             neg2_reg;
    logic [OUT_W-1:0] coord_reg;

    logic [31:0]      av;
    logic [62:0]      p1;
    logic [49:0]      p2;
    logic [49:0]      lim;
    logic [OUT_W-1:0] sat;

    always_comb begin
        av  = base.neg ? (TWO_Q - {1'b0, base.mag}) : (TWO_Q + {1'b0, base.mag});
        p1  = av * fac.mag;
        p2  = m_reg * radius + RND_HALF;
        if (neg2_reg) begin
            lim = (m2_reg > OUT_MIN_MAG) ? OUT_MIN_MAG : m2_reg;
            sat = OUT_W'(50'd0 - lim);
        end else begin
            lim = (m2_reg > OUT_MAX) ? OUT_MAX : m2_reg;
            sat = lim[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg     <= p1[62:30];
            neg1_reg  <= fac.neg;
            m2_reg    <= p2 >> RND_SH;
            neg2_reg  <= neg1_reg;
            coord_reg <= sat;
        end
    end

    assign coord = coord_reg;

endmodule

// ----- rtl/saddle_torus_point_eval.sv -----
`timescale 1ns / 1ps

// Saddle torus point evaluator.
// s_ channel: one word per point, u phase in tdata[15:0], v phase in tdata[31:16],
// each a fraction of a full turn. m_ channel: x, y, z coordinates, signed with
// 8 fraction bits, saturated. cfg_we/cfg_wdata set the radius (unsigned Q8.8);
// write it only while no point is in flight.
// Throughput: one point per cycle while m_tready does not stall the pipeline. A point runs
// through the sine/cosine Horner stages (8), the square and 31-step root chain (33),
// the scaling multiplies (3) and the output register before m_tvalid.
// Reset (aresetn low, synchronous) clears all valid bits and sets radius to 1.0.
// When the receiver holds m_tready low, the result stays in the output register;
// the pipeline keeps taking words until its last stage also holds a result, then
// s_tready drops and everything holds in place until m_tready returns.
module saddle_torus_point_eval import stpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // u_phase[15:0], v_phase[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // x_coord[18:0], y_coord[37:19], z_coord[56:38], zero
);

    logic [15:0]      radius_reg;
    logic             valid_reg [0:PIPE_LAT-1];
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    logic             en;
    logic [TURN_BITS-1:0] pu;
    logic [TURN_BITS-1:0] pv;
    sm_t              cu, cu3, cv, cv3, gu, gv;
    sm_t              cu_d_reg  [0:FR_LAT-1];
    sm_t              cu3_d_reg [0:FR_LAT-1];
    sm_t              cv_d_reg  [0:FR_LAT-1];
    sm_t              cv3_d_reg [0:FR_LAT-1];
    logic [OUT_W-1:0] x_c, y_c, z_c;

    // advance unless the last stage and the output register both hold results and m_tready is low
    assign en       = !(valid_reg[PIPE_LAT-1] && m_tvalid_reg && !m_tready);
    assign s_tready = en;

    assign pu = TURN_BITS'({16'd0, s_tdata[15:0]} << (TURN_BITS - PHASE_BITS));
    assign pv = TURN_BITS'({16'd0, s_tdata[31:16]} << (TURN_BITS - PHASE_BITS));

    stpe_cos u_cos_u  (.aclk(aclk), .en(en), .phase(pu),              .cos_o(cu));
    stpe_cos u_cos_u3 (.aclk(aclk), .en(en), .phase(pu + THIRD_TURN), .cos_o(cu3));
    stpe_cos u_cos_v  (.aclk(aclk), .en(en), .phase(pv),              .cos_o(cv));
    stpe_cos u_cos_v3 (.aclk(aclk), .en(en), .phase(pv + THIRD_TURN), .cos_o(cv3));

    stpe_froot u_root_u (.aclk(aclk), .en(en), .cos_a(cu), .cos_b(cu3), .root_o(gu));
    stpe_froot u_root_v (.aclk(aclk), .en(en), .cos_a(cv), .cos_b(cv3), .root_o(gv));

    // hold the cosines while the roots are computed
    always_ff @(posedge aclk) begin
        if (en) begin
            cu_d_reg[0]  <= cu;
            cu3_d_reg[0] <= cu3;
            cv_d_reg[0]  <= cv;
            cv3_d_reg[0] <= cv3;
            for (int k = 1; k < FR_LAT; k++) begin
                cu_d_reg[k]  <= cu_d_reg[k-1];
                cu3_d_reg[k] <= cu3_d_reg[k-1];
                cv_d_reg[k]  <= cv_d_reg[k-1];
                cv3_d_reg[k] <= cv3_d_reg[k-1];
            end
        end
    end

    stpe_scale u_scale_x (.aclk(aclk), .en(en), .base(cu_d_reg[FR_LAT-1]),
                          .fac(cv_d_reg[FR_LAT-1]), .radius(radius_reg), .coord(x_c));
    stpe_scale u_scale_y (.aclk(aclk), .en(en), .base(cu3_d_reg[FR_LAT-1]),
                          .fac(cv3_d_reg[FR_LAT-1]), .radius(radius_reg), .coord(y_c));
    stpe_scale u_scale_z (.aclk(aclk), .en(en), .base(gu), .fac(gv),
                          .radius(radius_reg), .coord(z_c));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd256;
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                valid_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en) begin
                valid_reg[0] <= s_tvalid;
                for (int k = 1; k < PIPE_LAT; k++) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (en && valid_reg[PIPE_LAT-1]) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && valid_reg[PIPE_LAT-1]) begin
            m_tdata_reg <= {7'd0, z_c, y_c, x_c};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
